// ===== design/eet_pkg.sv =====
// eet_pkg: shared types and constants of the expiring entry table
// request codes, result codes and controller states; no dependencies
package eet_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int KEY_W        = 64;
    localparam int TIME_W       = 64;
    localparam int REQ_W        = 2;
    localparam int STATUS_W     = 3;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_EXPIRE = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED    = 3'd0,
        ST_DUP      = 3'd1,
        ST_FULL     = 3'd2,
        ST_REMOVED  = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_CLEARED  = 3'd5,
        ST_EXPIRED  = 3'd6,
        ST_DONE     = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_RESOLVE
    } state_t;

endpackage

// ===== design/eet_req_if.sv =====
// eet_req_if: request channel of the expiring entry table
// valid/ready handshake with the request payload; no dependencies
interface eet_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [63:0] entry_key;
    logic [63:0] expiry_time;
    logic [63:0] current_time;

    modport source (output valid, output req_type, output entry_key,
                    output expiry_time, output current_time, input ready);
    modport sink   (input valid, input req_type, input entry_key,
                    input expiry_time, input current_time, output ready);
endinterface

// ===== design/eet_rsp_if.sv =====
// eet_rsp_if: result channel of the expiring entry table
// valid/ready handshake with the result payload; no dependencies
interface eet_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [63:0] expired_key;
    logic [63:0] expired_time;
    logic        last_result;

    modport source (output valid, output status, output expired_key,
                    output expired_time, output last_result, input ready);
    modport sink   (input valid, input status, input expired_key,
                    input expired_time, input last_result, output ready);
endinterface

// ===== design/eet_mem.sv =====
// eet_mem: slot storage, one write port and one read port, registered read
// holds key and expiry of each slot; no dependencies
module eet_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int DW    = 128
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/eet_ctrl.sv =====
// eet_ctrl: sequencer that walks the slot memory, valid bits and result register
// depends on eet_pkg and the request/result interfaces
module eet_ctrl
    import eet_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int IDX_W    = $clog2(CAPACITY)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    eet_req_if.sink                   req,
    eet_rsp_if.source                 rsp,
    output logic                      mem_wr_en,
    output logic [IDX_W-1:0]          mem_wr_addr,
    output logic [KEY_W+TIME_W-1:0]   mem_wr_data,
    output logic                      mem_rd_en,
    output logic [IDX_W-1:0]          mem_rd_addr,
    input  logic [KEY_W+TIME_W-1:0]   mem_rd_data
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    state_t state_reg, state_next;

    logic [CAPACITY-1:0] valid_reg;
    logic [IDX_W-1:0]    cnt_reg;
    logic                rd_pend_reg;
    logic [IDX_W-1:0]    rd_idx_reg;

    req_t                op_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [TIME_W-1:0]   exp_reg;
    logic [TIME_W-1:0]   now_reg;

    logic                hit_reg;
    logic [IDX_W-1:0]    hit_idx_reg;
    logic                free_found_reg;
    logic [IDX_W-1:0]    free_idx_reg;
    logic [KEY_W-1:0]    best_key_reg;
    logic [TIME_W-1:0]   best_exp_reg;

    logic                rsp_valid_reg;
    status_t             status_reg;
    logic [KEY_W-1:0]    out_key_reg;
    logic [TIME_W-1:0]   out_time_reg;
    logic                last_reg;

    logic                accept;
    logic                out_free;
    req_t                in_type;
    logic [KEY_W-1:0]    rd_key;
    logic [TIME_W-1:0]   rd_exp;
    logic                rd_valid;
    logic                key_match;
    logic                expired;
    logic                better;

    // controller strobes
    logic                start_scan;
    logic                load_out;
    status_t             out_status;
    logic                out_last;
    logic                out_entry;
    logic                set_valid;
    logic                clr_valid;
    logic                clr_all;

    assign in_type  = req_t'(req.req_type);
    assign accept   = req.valid && req.ready;
    assign out_free = !rsp_valid_reg || rsp.ready;

    assign rd_key   = mem_rd_data[KEY_W+TIME_W-1:TIME_W];
    assign rd_exp   = mem_rd_data[TIME_W-1:0];
    assign rd_valid = valid_reg[rd_idx_reg];

    assign key_match = rd_pend_reg && rd_valid && (rd_key == key_reg);
    assign expired   = rd_pend_reg && rd_valid && (rd_exp < now_reg);
    // earliest expiry first, ties go to the smaller key
    assign better    = !hit_reg || (rd_exp < best_exp_reg) ||
                       ((rd_exp == best_exp_reg) && (rd_key < best_key_reg));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_type)
                        REQ_ADD, REQ_REMOVE: state_next = S_SCAN;
                        REQ_CLEAR:           state_next = S_RESOLVE;
                        REQ_EXPIRE:
                        begin
                            if (req.current_time != '0)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:             state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_RESOLVE;
            end
            S_RESOLVE:
            begin
                if (out_free)
                begin
                    if (op_reg == REQ_EXPIRE && hit_reg)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        start_scan = (state_next == S_SCAN) && (state_reg != S_SCAN);
        mem_rd_en  = (state_reg == S_SCAN);
        load_out   = 1'b0;
        out_status = ST_DONE;
        out_last   = 1'b1;
        out_entry  = 1'b0;
        set_valid  = 1'b0;
        clr_valid  = 1'b0;
        clr_all    = 1'b0;
        mem_wr_en  = 1'b0;
        if (state_reg == S_RESOLVE && out_free)
        begin
            load_out = 1'b1;
            case (op_reg)
                REQ_ADD:
                begin
                    if (hit_reg)
                    begin
                        out_status = ST_DUP;
                    end
                    else if (free_found_reg)
                    begin
                        out_status = ST_ADDED;
                        set_valid  = 1'b1;
                        mem_wr_en  = 1'b1;
                    end
                    else
                    begin
                        out_status = ST_FULL;
                    end
                end
                REQ_REMOVE:
                begin
                    if (hit_reg)
                    begin
                        out_status = ST_REMOVED;
                        clr_valid  = 1'b1;
                    end
                    else
                    begin
                        out_status = ST_NOTFOUND;
                    end
                end
                REQ_CLEAR:
                begin
                    out_status = ST_CLEARED;
                    clr_all    = 1'b1;
                end
                REQ_EXPIRE:
                begin
                    if (hit_reg)
                    begin
                        out_status = ST_EXPIRED;
                        out_last   = 1'b0;
                        out_entry  = 1'b1;
                        clr_valid  = 1'b1;
                    end
                    else
                    begin
                        out_status = ST_DONE;
                    end
                end
                default: out_status = ST_DONE;
            endcase
        end
    end

    assign mem_rd_addr = cnt_reg;
    assign mem_wr_addr = free_idx_reg;
    assign mem_wr_data = {key_reg, exp_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            cnt_reg        <= '0;
            rd_pend_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= mem_rd_en;

            if (start_scan)
            begin
                cnt_reg <= '0;
            end
            else if (mem_rd_en)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            if (start_scan)
            begin
                hit_reg        <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (rd_pend_reg)
            begin
                if (op_reg == REQ_EXPIRE)
                begin
                    if (expired && better)
                    begin
                        hit_reg <= 1'b1;
                    end
                end
                else
                begin
                    if (key_match)
                    begin
                        hit_reg <= 1'b1;
                    end
                    if (!rd_valid && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                    end
                end
            end

            if (clr_all)
            begin
                valid_reg <= '0;
            end
            else if (set_valid)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
            end
            else if (clr_valid)
            begin
                valid_reg[hit_idx_reg] <= 1'b0;
            end

            if (load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= cnt_reg;
        if (accept)
        begin
            op_reg  <= in_type;
            key_reg <= req.entry_key;
            exp_reg <= req.expiry_time;
            now_reg <= req.current_time;
        end
        if (rd_pend_reg)
        begin
            if (op_reg == REQ_EXPIRE)
            begin
                if (expired && better)
                begin
                    hit_idx_reg  <= rd_idx_reg;
                    best_key_reg <= rd_key;
                    best_exp_reg <= rd_exp;
                end
            end
            else
            begin
                if (key_match)
                begin
                    hit_idx_reg <= rd_idx_reg;
                end
                if (!rd_valid && !free_found_reg)
                begin
                    free_idx_reg <= rd_idx_reg;
                end
            end
        end
        if (load_out)
        begin
            status_reg   <= out_status;
            last_reg     <= out_last;
            out_key_reg  <= out_entry ? best_key_reg : '0;
            out_time_reg <= out_entry ? best_exp_reg : '0;
        end
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.expired_key  = out_key_reg;
    assign rsp.expired_time = out_time_reg;
    assign rsp.last_result  = last_reg;

endmodule

// ===== design/expiring_entry_table_core.sv =====
// add and remove walk all CAPACITY slots before their result beat; clear walks no slot
// expire walks all slots for each expired-entry beat; done ends a last walk that finds none
// one request at a time: a new request is taken only in idle, after the previous one resolved
// reset clears the valid bits and the handshake state; slot memory is not cleared
// a request is taken while the previous result still waits in the output register
module expiring_entry_table_core
    import eet_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    eet_req_if.sink    req,
    eet_rsp_if.source  rsp
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int DW    = KEY_W + TIME_W;

    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    logic [DW-1:0]    mem_wr_data;
    logic             mem_rd_en;
    logic [IDX_W-1:0] mem_rd_addr;
    logic [DW-1:0]    mem_rd_data;

    eet_ctrl #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    eet_mem #(
        .DEPTH (CAPACITY),
        .AW    (IDX_W),
        .DW    (DW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // a slot is only written while no walk is reading the memory
    a_no_wr_during_walk: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> !mem_rd_en)
        else $error("slot write overlaps a memory walk");

    // every slot write comes with an added result beat
    a_wr_means_added: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |=> (rsp.valid && rsp.status == ST_ADDED && rsp.last_result))
        else $error("slot written without an added result");

    // only expired-entry beats leave a request unfinished
    a_last_vs_expired: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> ((rsp.status == ST_EXPIRED) == !rsp.last_result))
        else $error("last_result does not match status");

    // entry fields are zero unless an entry is reported
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_EXPIRED)
            |-> (rsp.expired_key == '0 && rsp.expired_time == '0))
        else $error("entry fields set on a non-expiry beat");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// testbench for expiring_entry_table_core: random and directed requests with a
// table predictor that scores every result beat; needs eet_pkg, eet_req_if, eet_rsp_if
module testbench;
    import eet_pkg::*;

    localparam int TABLE_SIZE    = CAPACITY_DEF;
    localparam int KEY_POOL      = 40;
    localparam int RANDOM_ITEMS  = 410;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 6000;
    localparam int SETTLE_CYCLES = 2 * (TABLE_SIZE + 3);
    localparam int PRINT_CAP     = 40;
    localparam logic [63:0] ALL_ONES = '1;

    typedef struct {
        req_t        kind;
        logic [63:0] key;
        logic [63:0] expiry;
        logic [63:0] now;
    } table_req_t;

    typedef struct {
        status_t     status;
        logic [63:0] key;
        logic [63:0] expiry;
        logic        last;
    } table_rsp_t;

    class entry_table_tracker;
        bit          live [TABLE_SIZE];
        logic [63:0] keys [TABLE_SIZE];
        logic [63:0] expiries [TABLE_SIZE];
        table_rsp_t  due_results [$];
        int          errors;
        int          printed;
        int          beats_checked;
        int          status_seen [8];

        function new();
            foreach (live[i]) live[i] = 1'b0;
            errors = 0;
            printed = 0;
            beats_checked = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function int slot_of(logic [63:0] key);
            for (int i = 0; i < TABLE_SIZE; i++)
                if (live[i] && keys[i] == key) return i;
            return -1;
        endfunction

        function void push_due(status_t s, logic [63:0] k, logic [63:0] t, logic last);
            table_rsp_t r;
            r.status = s;
            r.key    = k;
            r.expiry = t;
            r.last   = last;
            due_results.push_back(r);
        endfunction

        function void note_request(table_req_t r);
            int hit;
            int spare;
            int oldest;
            case (r.kind)
                REQ_ADD:
                begin
                    hit = slot_of(r.key);
                    spare = -1;
                    for (int i = TABLE_SIZE - 1; i >= 0; i--)
                        if (!live[i]) spare = i;
                    if (hit >= 0)
                        push_due(ST_DUP, '0, '0, 1'b1);
                    else if (spare < 0)
                        push_due(ST_FULL, '0, '0, 1'b1);
                    else
                    begin
                        live[spare]     = 1'b1;
                        keys[spare]     = r.key;
                        expiries[spare] = r.expiry;
                        push_due(ST_ADDED, '0, '0, 1'b1);
                    end
                end
                REQ_REMOVE:
                begin
                    hit = slot_of(r.key);
                    if (hit >= 0)
                    begin
                        live[hit] = 1'b0;
                        push_due(ST_REMOVED, '0, '0, 1'b1);
                    end
                    else
                        push_due(ST_NOTFOUND, '0, '0, 1'b1);
                end
                REQ_CLEAR:
                begin
                    foreach (live[i]) live[i] = 1'b0;
                    push_due(ST_CLEARED, '0, '0, 1'b1);
                end
                default:
                begin
                    // a sweep at time zero is silently dropped
                    if (r.now != '0)
                    begin
                        while (1'b1)
                        begin
                            oldest = -1;
                            for (int i = 0; i < TABLE_SIZE; i++)
                            begin
                                if (live[i] && expiries[i] < r.now)
                                    if (oldest < 0 || expiries[i] < expiries[oldest] ||
                                        (expiries[i] == expiries[oldest] &&
                                         keys[i] < keys[oldest]))
                                        oldest = i;
                            end
                            if (oldest < 0) break;
                            push_due(ST_EXPIRED, keys[oldest], expiries[oldest], 1'b0);
                            live[oldest] = 1'b0;
                        end
                        push_due(ST_DONE, '0, '0, 1'b1);
                    end
                end
            endcase
        endfunction

        task report(string msg);
            errors++;
            if (printed < PRINT_CAP)
            begin
                $display("mismatch at %0t: %s", $realtime, msg);
                printed++;
            end
        endtask

        task check_result(table_rsp_t got);
            table_rsp_t want;
            beats_checked++;
            if (due_results.size() == 0)
            begin
                report($sformatf("beat with status %0d while nothing is due", got.status));
                return;
            end
            want = due_results.pop_front();
            status_seen[want.status]++;
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.key !== want.key)
                report($sformatf("expired_key %h, want %h", got.key, want.key));
            if (got.expiry !== want.expiry)
                report($sformatf("expired_time %h, want %h", got.expiry, want.expiry));
            if (got.last !== want.last)
                report($sformatf("last_result %b, want %b", got.last, want.last));
        endtask

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    eet_req_if req_ch ();
    eet_rsp_if rsp_ch ();

    expiring_entry_table_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    entry_table_tracker tracker = new();

    logic [63:0] key_pool [KEY_POOL];
    logic [63:0] time_base;
    bit          hold_request;
    int          idle_cycles;
    int          burst_left;
    int          accepted_items;
    int          ignored_sweeps;
    int          counted;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic table_req_t make_req(req_t kind, logic [63:0] key,
                                            logic [63:0] expiry, logic [63:0] now);
        table_req_t r;
        r.kind   = kind;
        r.key    = key;
        r.expiry = expiry;
        r.now    = now;
        return r;
    endfunction

    function automatic logic [63:0] pick_time();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) return time_base + $urandom_range(0, 255);
        if (pick < 80) return '0;
        if (pick < 90) return rand64();
        return ALL_ONES;
    endfunction

    function automatic table_req_t random_req(int mode);
        table_req_t r;
        int pick;
        pick = $urandom_range(0, 99);
        case (mode)
            0:       r.kind = pick < 45 ? REQ_ADD : pick < 65 ? REQ_REMOVE :
                              pick < 68 ? REQ_CLEAR : REQ_EXPIRE;
            1:       r.kind = pick < 85 ? REQ_ADD : pick < 93 ? REQ_REMOVE : REQ_EXPIRE;
            default: r.kind = pick < 20 ? REQ_ADD : pick < 50 ? REQ_REMOVE :
                              pick < 52 ? REQ_CLEAR : REQ_EXPIRE;
        endcase
        r.key    = ($urandom_range(0, 3) != 0) ? key_pool[$urandom_range(0, KEY_POOL - 1)]
                                               : rand64();
        r.expiry = pick_time();
        r.now    = pick_time();
        return r;
    endfunction

    task automatic drive_request(table_req_t r);
        @(negedge clk);
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= r.kind;
        req_ch.entry_key    <= r.key;
        req_ch.expiry_time  <= r.expiry;
        req_ch.current_time <= r.now;
        do @(posedge clk); while (!req_ch.ready);
        tracker.note_request(r);
        accepted_items++;
        if (r.kind == REQ_EXPIRE && r.now == '0) ignored_sweeps++;
    endtask

    // bursts of random length, random gaps, now and then a long unbroken run
    task automatic issue_request(table_req_t r);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 30);
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                @(negedge clk);
                req_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        drive_request(r);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        burst_left = 0;
        while (tracker.pending() != 0) @(posedge clk);
    endtask

    // result beats are sampled at the rising edge; the watchdog counts dead cycles
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                tracker.check_result('{status_t'(rsp_ch.status), rsp_ch.expired_key,
                                       rsp_ch.expired_time, rsp_ch.last_result});
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles, %0d results due",
                         STALL_LIMIT, tracker.pending());
                $display("testbench: errors");
                $finish;
            end
        end
    end

    // receiver: windows of differing stall patterns, plus one long hold on request
    initial
    begin
        int window;
        int style;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            window = $urandom_range(16, 96);
            style  = $urandom_range(0, 3);
            for (int n = 0; n < window; n++)
            begin
                @(negedge clk);
                if (hold_request)
                begin
                    rsp_ch.ready <= 1'b0;
                    repeat (HOLD_CYCLES - 1) @(negedge clk);
                    hold_request = 1'b0;
                end
                else
                begin
                    case (style)
                        0:       rsp_ch.ready <= 1'b1;
                        1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                        2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                        default: rsp_ch.ready <= n[2];
                    endcase
                end
            end
        end
    end

    initial
    begin
        int mode;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = REQ_ADD;
        req_ch.entry_key    = '0;
        req_ch.expiry_time  = '0;
        req_ch.current_time = '0;
        rst_n          = 1'b0;
        hold_request   = 1'b0;
        idle_cycles    = 0;
        burst_left     = 0;
        accepted_items = 0;
        ignored_sweeps = 0;
        time_base      = 64'd1000;
        key_pool[0]    = '0;
        key_pool[1]    = ALL_ONES;
        for (int i = 2; i < KEY_POOL; i++) key_pool[i] = rand64();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // directed: empty table cases, extremes, ties, zero time, duplicate
        issue_request(make_req(REQ_CLEAR,  rand64(), rand64(), rand64()));
        issue_request(make_req(REQ_REMOVE, ALL_ONES, rand64(), rand64()));
        issue_request(make_req(REQ_EXPIRE, rand64(), rand64(), '0));
        issue_request(make_req(REQ_EXPIRE, rand64(), rand64(), 64'd1));
        issue_request(make_req(REQ_ADD,    '0, '0, rand64()));
        issue_request(make_req(REQ_ADD,    ALL_ONES, ALL_ONES, rand64()));
        issue_request(make_req(REQ_ADD,    '0, 64'd77, rand64()));
        issue_request(make_req(REQ_ADD,    64'd5, 64'd10, rand64()));
        issue_request(make_req(REQ_ADD,    64'd3, 64'd10, rand64()));
        issue_request(make_req(REQ_ADD,    64'h8000_0000_0000_0000, 64'd9, rand64()));
        issue_request(make_req(REQ_EXPIRE, rand64(), rand64(), '0));
        issue_request(make_req(REQ_EXPIRE, rand64(), rand64(), 64'd10));
        issue_request(make_req(REQ_EXPIRE, rand64(), rand64(), ALL_ONES));
        issue_request(make_req(REQ_REMOVE, ALL_ONES, rand64(), rand64()));
        issue_request(make_req(REQ_REMOVE, ALL_ONES, rand64(), rand64()));
        issue_request(make_req(REQ_ADD,    64'd7, 64'd3, rand64()));
        issue_request(make_req(REQ_CLEAR,  rand64(), rand64(), rand64()));
        issue_request(make_req(REQ_EXPIRE, rand64(), rand64(), 64'd100));

        // fill past capacity while the receiver holds off, then sweep everything
        wait_drained();
        drive_request(make_req(REQ_CLEAR, rand64(), rand64(), rand64()));
        hold_request = 1'b1;
        drive_request(make_req(REQ_ADD, key_pool[5], '0, rand64()));
        drive_request(make_req(REQ_ADD, key_pool[6], ALL_ONES - 1, rand64()));
        for (int i = 0; i < TABLE_SIZE - 1; i++)
            drive_request(make_req(REQ_ADD, rand64(), 64'($urandom_range(1, 40)), rand64()));
        drive_request(make_req(REQ_ADD, key_pool[5], 64'd3, rand64()));
        wait_drained();
        issue_request(make_req(REQ_EXPIRE, rand64(), rand64(), ALL_ONES));
        issue_request(make_req(REQ_EXPIRE, rand64(), rand64(), ALL_ONES));

        counted = 0;
        mode = 0;
        while (counted < RANDOM_ITEMS)
        begin
            table_req_t r;
            if (counted % 24 == 0)
            begin
                mode = $urandom_range(0, 2);
                if ($urandom_range(0, 3) == 0) wait_drained();
            end
            r = random_req(mode);
            issue_request(r);
            time_base += $urandom_range(0, 8);
            if (!(r.kind == REQ_EXPIRE && r.now == '0)) counted++;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d requests taken (%0d zero-time sweeps), %0d result beats scored",
                 accepted_items, ignored_sweeps, tracker.beats_checked);
        $display("added %0d dup %0d full %0d removed %0d missing %0d cleared %0d %s",
                 tracker.status_seen[ST_ADDED], tracker.status_seen[ST_DUP],
                 tracker.status_seen[ST_FULL], tracker.status_seen[ST_REMOVED],
                 tracker.status_seen[ST_NOTFOUND], tracker.status_seen[ST_CLEARED],
                 $sformatf("expired %0d done %0d", tracker.status_seen[ST_EXPIRED],
                           tracker.status_seen[ST_DONE]));
        if (tracker.errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
